// ----- rtl/rti_pkg.sv -----
// Shared types, register indexes and constants for the ray/triangle block.
// No dependencies; used by rti_div and ray_triangle_intersect.
package rti_pkg;

	// default coordinate width (signed, 16 fraction bits)
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int FRAC_BITS       = 16;
	localparam int QUO_BITS        = 31;

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 63;

	localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DIR_X    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [CFG_IW-1:0] REG_DET_EPS  = 3'd6;

	localparam logic [QUO_BITS-1:0] DIST_MAX = {QUO_BITS{1'b1}};

	typedef struct packed {
		logic signed [FIELD_W-1:0] vertex_a_x;
		logic signed [FIELD_W-1:0] vertex_a_y;
		logic signed [FIELD_W-1:0] vertex_a_z;
		logic signed [FIELD_W-1:0] vertex_b_x;
		logic signed [FIELD_W-1:0] vertex_b_y;
		logic signed [FIELD_W-1:0] vertex_b_z;
		logic signed [FIELD_W-1:0] vertex_c_x;
		logic signed [FIELD_W-1:0] vertex_c_y;
		logic signed [FIELD_W-1:0] vertex_c_z;
	} item_t;

	typedef struct packed {
		logic                hit;
		logic [QUO_BITS-1:0] distance;
	} result_t;

	// per-stage control travelling alongside the divider data
	typedef struct packed {
		logic valid;
		logic hit;
		logic sat;
	} rti_ctl_t;

endpackage

// ----- rtl/ray_triangle_intersect.sv -----
// Ray/triangle intersection by Cramer's rule; one triangle per cycle.
// Path from request accept to result valid: 8 arithmetic
// stages, 31 divider stages, output register. Throughput: one per clock.
// The whole pipeline stalls only while the output register holds an untaken result.
// Reset clears all ray registers to zero and empties the pipeline.
// Depends on rti_pkg and rti_div.
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	localparam int W  = COORD_WIDTH;
	localparam int XW = W + 1;            // differences
	localparam int PW = 2 * W + 2;        // first products
	localparam int CW = 2 * W + 3;        // cross components
	localparam int DW = 3 * W + 6;        // determinants
	localparam int EW = (DW > CFG_DW) ? DW : CFG_DW;
	localparam int RW = DW + QUO_BITS;
	localparam int SW = DW + QUO_BITS - FRAC_BITS;

	localparam int N1 [3] = '{1, 2, 0};
	localparam int N2 [3] = '{2, 0, 1};
	localparam int KS [4] = '{0, 0, 1, 2};

	// low W bits of a field, sign extended (wider widths see the field zero extended)
	function automatic logic signed [W-1:0] coord(input logic [FIELD_W-1:0] f);
		logic [2*FIELD_W+W-1:0] z;
		z = {{(FIELD_W+W){1'b0}}, f};
		return signed'(z[W-1:0]);
	endfunction

	logic                en;
	logic [FIELD_W-1:0]  origin_q [3];
	logic [FIELD_W-1:0]  dir_q    [3];
	logic [CFG_DW-1:0]   eps_q;

	// ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				dir_q[i]    <= '0;
			end
			eps_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_q[0] <= cfg_wdata[FIELD_W-1:0];
				REG_ORIGIN_Y: origin_q[1] <= cfg_wdata[FIELD_W-1:0];
				REG_ORIGIN_Z: origin_q[2] <= cfg_wdata[FIELD_W-1:0];
				REG_DIR_X:    dir_q[0]    <= cfg_wdata[FIELD_W-1:0];
				REG_DIR_Y:    dir_q[1]    <= cfg_wdata[FIELD_W-1:0];
				REG_DIR_Z:    dir_q[2]    <= cfg_wdata[FIELD_W-1:0];
				REG_DET_EPS:  eps_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// global advance: move whenever the output register can take a result
	assign en         = !result_valid || result_ready;
	assign item_ready = en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: edge vectors, origin offset, negated direction
	logic signed [W-1:0]  va [3], vb [3], vc [3];
	logic signed [XW-1:0] e1_d [3], e2_d [3], s_d [3], nd_d [3];
	logic signed [XW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3], nd_s1 [3];

	always_comb begin
		va[0] = coord(item.vertex_a_x); va[1] = coord(item.vertex_a_y);
		va[2] = coord(item.vertex_a_z);
		vb[0] = coord(item.vertex_b_x); vb[1] = coord(item.vertex_b_y);
		vb[2] = coord(item.vertex_b_z);
		vc[0] = coord(item.vertex_c_x); vc[1] = coord(item.vertex_c_y);
		vc[2] = coord(item.vertex_c_z);
		for (int i = 0; i < 3; i++) begin
			e1_d[i] = XW'(vb[i]) - XW'(va[i]);
			e2_d[i] = XW'(vc[i]) - XW'(va[i]);
			s_d[i]  = XW'(coord(origin_q[i])) - XW'(va[i]);
			nd_d[i] = -XW'(coord(dir_q[i]));
		end
	end

	// stage 2: cross product terms, k=0 e2 x nd, k=1 nd x e1, k=2 e1 x e2
	logic signed [PW-1:0] pa_s2 [3][3], pb_s2 [3][3];
	logic signed [XW-1:0] e1_s2 [3], s_s2 [3];
	// stage 3: cross components
	logic signed [CW-1:0] cr_s3 [3][3];
	logic signed [XW-1:0] e1_s3 [3], s_s3 [3];
	// stage 4: split dot product partials; m = det, du, dv, dt
	logic signed [CW-1:0] lo_s4 [4][3], hi_s4 [4][3];
	// stage 5: full products; stage 6: determinants; stage 7: sign fixed
	logic signed [DW-1:0] pr_s5 [4][3];
	logic signed [DW-1:0] dsum_s6 [4];
	logic signed [DW-1:0] d_s7 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= e1_d[i];
				e2_s1[i] <= e2_d[i];
				s_s1[i]  <= s_d[i];
				nd_s1[i] <= nd_d[i];
			end
			for (int i = 0; i < 3; i++) begin
				pa_s2[0][i] <= e2_s1[N1[i]] * nd_s1[N2[i]];
				pb_s2[0][i] <= e2_s1[N2[i]] * nd_s1[N1[i]];
				pa_s2[1][i] <= nd_s1[N1[i]] * e1_s1[N2[i]];
				pb_s2[1][i] <= nd_s1[N2[i]] * e1_s1[N1[i]];
				pa_s2[2][i] <= e1_s1[N1[i]] * e2_s1[N2[i]];
				pb_s2[2][i] <= e1_s1[N2[i]] * e2_s1[N1[i]];
				e1_s2[i] <= e1_s1[i];
				s_s2[i]  <= s_s1[i];
			end
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					cr_s3[k][i] <= CW'(pa_s2[k][i]) - CW'(pb_s2[k][i]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				e1_s3[i] <= e1_s2[i];
				s_s3[i]  <= s_s2[i];
			end
			for (int m = 0; m < 4; m++) begin
				for (int i = 0; i < 3; i++) begin
					lo_s4[m][i] <= ((m == 0) ? e1_s3[i] : s_s3[i])
						* signed'({1'b0, cr_s3[KS[m]][i][XW-1:0]});
					hi_s4[m][i] <= ((m == 0) ? e1_s3[i] : s_s3[i])
						* signed'(cr_s3[KS[m]][i][CW-1:XW]);
				end
			end
			for (int m = 0; m < 4; m++) begin
				for (int i = 0; i < 3; i++) begin
					pr_s5[m][i] <= (DW'(hi_s4[m][i]) <<< XW) + DW'(lo_s4[m][i]);
				end
			end
			for (int m = 0; m < 4; m++) begin
				dsum_s6[m] <= pr_s5[m][0] + pr_s5[m][1] + pr_s5[m][2];
			end
			// negative det: negate det and all numerators
			for (int m = 0; m < 4; m++) begin
				d_s7[m] <= dsum_s6[0][DW-1] ? -dsum_s6[m] : dsum_s6[m];
			end
		end
	end

	// stage 8: bound tests on the determinants, saturation, divider operands
	logic [DW-1:0]   det_u, du_u, dv_u, dt_u;
	logic            hit_d, sat_d;
	logic            hit_s8, sat_s8;
	logic [RW-1:0]   num_s8;
	logic [DW-1:0]   den_s8;

	always_comb begin
		det_u = d_s7[0];
		du_u  = d_s7[1];
		dv_u  = d_s7[2];
		dt_u  = d_s7[3];
		hit_d = (EW'(det_u) > EW'(eps_q))
			&& !du_u[DW-1] && !dv_u[DW-1] && !dt_u[DW-1]
			&& (du_u <= det_u) && (dv_u <= det_u)
			&& ((DW+1)'(du_u) + (DW+1)'(dv_u) <= (DW+1)'(det_u));
		sat_d = SW'(dt_u) >= (SW'(det_u) << (QUO_BITS - FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s8 <= hit_d;
			sat_s8 <= sat_d;
			num_s8 <= RW'(dt_u) << FRAC_BITS;
			den_s8 <= det_u;
		end
	end

	// quotient dt * 2^16 / det
	rti_ctl_t            ctl_in, ctl_out;
	logic [QUO_BITS-1:0] quo;

	assign ctl_in = '{valid: v_s8, hit: hit_s8, sat: sat_s8};

	rti_div #(.DW(DW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_in),
		.num     (num_s8),
		.den     (den_s8),
		.ctl_out (ctl_out),
		.quo     (quo)
	);

	// output register
	logic    res_valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= ctl_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.hit      <= ctl_out.hit;
			res_q.distance <= !ctl_out.hit ? '0 : (ctl_out.sat ? DIST_MAX : quo);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a miss always reports zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.distance == '0)
		else $error("miss with non-zero distance");

	// no request is taken while the output register is blocked
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("request accepted during output stall");

	// a blocked result is not replaced
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(res_q))
		else $error("stalled result changed");

endmodule

// ----- rtl/rti_div.sv -----
// Pipelined restoring divider, one quotient bit per stage (QUO_BITS stages).
// Depends on rti_pkg.
module rti_div import rti_pkg::*; #(
	parameter int DW = 102
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  rti_ctl_t                   ctl_in,
	input  logic [DW+QUO_BITS-1:0]     num,
	input  logic [DW-1:0]              den,
	output rti_ctl_t                   ctl_out,
	output logic [QUO_BITS-1:0]        quo
);

	localparam int RW = DW + QUO_BITS;
	localparam int NS = QUO_BITS;

	logic [RW-1:0]       rem_c [NS];
	logic [DW-1:0]       den_c [NS];
	logic [QUO_BITS-1:0] q_c   [NS];
	rti_ctl_t            ctl_c [NS];
	logic [RW-1:0]       sh_c  [NS];
	logic                ge_c  [NS];

	logic [RW-1:0]       rem_q [1:NS-1];
	logic [DW-1:0]       den_q [1:NS-1];
	logic [QUO_BITS-1:0] q_q   [1:NS];
	rti_ctl_t            ctl_q [1:NS];

	// stage sources: stage 0 from the ports, the rest from registers
	always_comb begin
		rem_c[0] = num;
		den_c[0] = den;
		q_c[0]   = '0;
		ctl_c[0] = ctl_in;
		for (int j = 1; j < NS; j++) begin
			rem_c[j] = rem_q[j];
			den_c[j] = den_q[j];
			q_c[j]   = q_q[j];
			ctl_c[j] = ctl_q[j];
		end
	end

	// trial subtract of the shifted divisor, MSB first
	always_comb begin
		for (int j = 0; j < NS; j++) begin
			sh_c[j] = RW'(den_c[j]) << (NS - 1 - j);
			ge_c[j] = rem_c[j] >= sh_c[j];
		end
	end

	// control and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= NS; j++) ctl_q[j] <= '0;
		end else if (en) begin
			for (int j = 0; j < NS; j++) ctl_q[j+1] <= ctl_c[j];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NS; j++) begin
				q_q[j+1] <= q_c[j] | (QUO_BITS'(ge_c[j]) << (NS - 1 - j));
			end
			for (int j = 0; j < NS - 1; j++) begin
				rem_q[j+1] <= ge_c[j] ? rem_c[j] - sh_c[j] : rem_c[j];
				den_q[j+1] <= den_c[j];
			end
		end
	end

	assign ctl_out = ctl_q[NS];
	assign quo     = q_q[NS];

endmodule
